[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int MAG_W = 33;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic [1:0]         branch_taken;
        logic               degenerate;
    } t_out;

    // Per-item tag that travels with the data through the divider stages.
    typedef struct packed {
        t_branch    branch;
        logic       degen;
        logic [2:0] neg;
    } t_tag;

    // Tag plus the three numerator magnitudes, carried through the root stages.
    typedef struct packed {
        t_tag                  tag;
        logic [2:0][MAG_W-1:0] mag;
    } t_side;

endpackage

[rtl/rotation_matrix_to_quaternion_core.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Fully pipelined rotation matrix to unit quaternion conversion (Shepperd).
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the root takes one result bit per stage over
// 64 stages and each of the three dividers one quotient bit per stage over 33.
// The whole pipeline advances together and freezes while a result is refused.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // Width of a scaled dividend, magnitude times two to the FRAC_BITS.
    localparam int DW = MAG_W + FRAC_BITS;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // The pipeline moves as one whenever the output register is free or taken.
    logic en;
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;

    // ------------------------------------------------------------------
    // Stage P1: trace, diagonal comparisons and off-diagonal sums/differences.
    // ------------------------------------------------------------------
    logic                     r_p1_valid;
    logic signed [33:0]       r_p1_trace;
    logic                     r_p1_c01, r_p1_c02, r_p1_c12;
    logic signed [2:0][33:0]  r_p1_dg;
    logic signed [5:0][32:0]  r_p1_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid  <= i_in_valid;
            r_p1_trace  <= 34'(i_in_data.m00) + 34'(i_in_data.m11) + 34'(i_in_data.m22);
            r_p1_c01    <= i_in_data.m00 > i_in_data.m11;
            r_p1_c02    <= i_in_data.m00 > i_in_data.m22;
            r_p1_c12    <= i_in_data.m11 > i_in_data.m22;
            r_p1_dg[0]  <= 34'(i_in_data.m00);
            r_p1_dg[1]  <= 34'(i_in_data.m11);
            r_p1_dg[2]  <= 34'(i_in_data.m22);
            r_p1_off[0] <= 33'(i_in_data.m21) - 33'(i_in_data.m12);
            r_p1_off[1] <= 33'(i_in_data.m02) - 33'(i_in_data.m20);
            r_p1_off[2] <= 33'(i_in_data.m10) - 33'(i_in_data.m01);
            r_p1_off[3] <= 33'(i_in_data.m01) + 33'(i_in_data.m10);
            r_p1_off[4] <= 33'(i_in_data.m02) + 33'(i_in_data.m20);
            r_p1_off[5] <= 33'(i_in_data.m12) + 33'(i_in_data.m21);
        end
    end

    // ------------------------------------------------------------------
    // Stage P2: branch choice, root argument and the three numerators.
    // The numerators fill the non-main quaternion slots in ascending order.
    // ------------------------------------------------------------------
    t_branch                 n_branch;
    logic signed [63:0]      n_r;
    logic signed [2:0][32:0] n_num;
    t_side                   n_side;

    always_comb begin
        priority if (r_p1_trace > 34'sd0) begin
            n_branch = BR_TRACE;
        end else if (r_p1_c01 && r_p1_c02) begin
            n_branch = BR_X;
        end else if (r_p1_c12) begin
            n_branch = BR_Y;
        end else begin
            n_branch = BR_Z;
        end
        unique case (n_branch)
            BR_TRACE: begin
                n_r   = ONE + 64'(r_p1_trace);
                n_num = {r_p1_off[2], r_p1_off[1], r_p1_off[0]};
            end
            BR_X: begin
                n_r   = ONE + 64'(signed'(r_p1_dg[0])) - 64'(signed'(r_p1_dg[1]))
                      - 64'(signed'(r_p1_dg[2]));
                n_num = {r_p1_off[4], r_p1_off[3], r_p1_off[0]};
            end
            BR_Y: begin
                n_r   = ONE + 64'(signed'(r_p1_dg[1])) - 64'(signed'(r_p1_dg[0]))
                      - 64'(signed'(r_p1_dg[2]));
                n_num = {r_p1_off[5], r_p1_off[3], r_p1_off[1]};
            end
            default: begin
                n_r   = ONE + 64'(signed'(r_p1_dg[2])) - 64'(signed'(r_p1_dg[0]))
                      - 64'(signed'(r_p1_dg[1]));
                n_num = {r_p1_off[5], r_p1_off[4], r_p1_off[2]};
            end
        endcase
        n_side.tag.branch = n_branch;
        n_side.tag.degen  = n_r <= 64'sd0;
        for (int k = 0; k < 3; k++) begin
            n_side.tag.neg[k] = n_num[k][32];
            n_side.mag[k]     = n_num[k][32] ? MAG_W'(-n_num[k]) : MAG_W'(n_num[k]);
        end
    end

    // ------------------------------------------------------------------
    // Square root: 64 stages, each settles one root bit from two radicand
    // bits. The radicand is the root argument scaled by 2^(FRAC_BITS+2), so
    // the root is s = 2*sqrt(r). Remainder and trial wrap at 64 bits.
    // ------------------------------------------------------------------
    logic [63:0]  r_sq_rem   [0:63];
    logic [127:0] r_sq_rad   [0:63];
    logic [63:0]  r_sq_root  [0:64];
    t_side        r_sq_side  [0:64];
    logic         r_sq_valid [0:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (en) begin
            r_sq_valid[0] <= r_p1_valid;
            r_sq_rem[0]   <= '0;
            r_sq_root[0]  <= '0;
            r_sq_rad[0]   <= 128'(unsigned'(n_r)) << (FRAC_BITS + 2);
            r_sq_side[0]  <= n_side;
        end
    end

    for (genvar k = 0; k < 64; k++) begin : g_sqrt
        logic [63:0] n_rem, n_trial, n_root;
        always_comb begin
            n_rem   = {r_sq_rem[k][61:0], r_sq_rad[k][127:126]};
            n_trial = {r_sq_root[k][61:0], 2'b01};
            n_root  = {r_sq_root[k][62:0], 1'b0};
            if (n_rem >= n_trial) begin
                n_rem     = n_rem - n_trial;
                n_root[0] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_valid[k+1] <= r_sq_valid[k];
                r_sq_root[k+1]  <= n_root;
                r_sq_side[k+1]  <= r_sq_side[k];
            end
        end
        if (k < 63) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_rem[k+1] <= n_rem;
                    r_sq_rad[k+1] <= r_sq_rad[k] << 2;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: main part s/4, overflow test and initial remainder.
    // A quotient that reaches 2^33 saturates, so 33 quotient bits suffice.
    // ------------------------------------------------------------------
    logic [63:0]             r_dv_s     [0:32];
    logic [2:0][63:0]        r_dv_rem   [0:32];
    logic [2:0][MAG_W-1:0]   r_dv_low   [0:32];
    logic [2:0][MAG_W-1:0]   r_dv_q     [0:33];
    logic [2:0]              r_dv_ovf   [0:33];
    logic signed [31:0]      r_dv_main  [0:33];
    t_tag                    r_dv_tag   [0:33];
    logic                    r_dv_valid [0:33];

    logic [63:0]             n_s;
    logic [61:0]             n_quarter;
    logic [2:0][DW-1:0]      n_dd;
    logic [2:0][63:0]        n_hi;

    always_comb begin
        n_s       = r_sq_root[64];
        n_quarter = n_s[63:2];
        for (int k = 0; k < 3; k++) begin
            n_dd[k] = DW'(r_sq_side[64].mag[k]) << FRAC_BITS;
            n_hi[k] = 64'(n_dd[k][DW-1:MAG_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= r_sq_valid[64];
            r_dv_s[0]     <= n_s;
            r_dv_main[0]  <= (n_quarter > 62'(Q_MAX)) ? Q_MAX : signed'(n_quarter[31:0]);
            r_dv_tag[0]   <= r_sq_side[64].tag;
            r_dv_q[0]     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_dv_ovf[0][k] <= n_hi[k] >= n_s;
                r_dv_rem[0][k] <= n_hi[k];
                r_dv_low[0][k] <= n_dd[k][MAG_W-1:0];
            end
        end
    end

    // Restoring division, one quotient bit per stage for all three dividers.
    for (genvar j = 0; j < 33; j++) begin : g_div
        logic [2:0][64:0] n_t;
        logic [2:0]       n_bit;
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                n_t[k]   = {r_dv_rem[j][k], r_dv_low[j][k][MAG_W-1]};
                n_bit[k] = n_t[k] >= {1'b0, r_dv_s[j]};
                if (n_bit[k]) begin
                    n_t[k] = n_t[k] - {1'b0, r_dv_s[j]};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_valid[j+1] <= r_dv_valid[j];
                r_dv_main[j+1]  <= r_dv_main[j];
                r_dv_tag[j+1]   <= r_dv_tag[j];
                r_dv_ovf[j+1]   <= r_dv_ovf[j];
                for (int k = 0; k < 3; k++) begin
                    r_dv_q[j+1][k] <= {r_dv_q[j][k][MAG_W-2:0], n_bit[k]};
                end
            end
        end
        if (j < 32) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_s[j+1] <= r_dv_s[j];
                    for (int k = 0; k < 3; k++) begin
                        r_dv_rem[j+1][k] <= n_t[k][63:0];
                        r_dv_low[j+1][k] <= r_dv_low[j][k] << 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F1: apply sign and saturate each quotient to 32 bits.
    // ------------------------------------------------------------------
    logic                    r_f1_valid;
    logic signed [2:0][31:0] r_f1_part;
    logic signed [31:0]      r_f1_main;
    t_tag                    r_f1_tag;
    logic signed [2:0][31:0] n_part;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_dv_tag[33].neg[k]) begin
                n_part[k] = (r_dv_ovf[33][k] || r_dv_q[33][k] >= 33'h0_8000_0000)
                          ? Q_MIN : -signed'(r_dv_q[33][k][31:0]);
            end else begin
                n_part[k] = (r_dv_ovf[33][k] || r_dv_q[33][k] > 33'(Q_MAX))
                          ? Q_MAX : signed'(r_dv_q[33][k][31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= r_dv_valid[33];
            r_f1_part  <= n_part;
            r_f1_main  <= r_dv_main[33];
            r_f1_tag   <= r_dv_tag[33];
        end
    end

    // ------------------------------------------------------------------
    // Stage F2: place parts in their slots, force w non-negative, register
    // the result. A degenerate root argument gives a zero quaternion.
    // ------------------------------------------------------------------
    logic                    r_out_valid;
    t_out                    r_out;
    logic signed [3:0][31:0] n_slot;
    t_out                    n_out;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (j == int'(r_f1_tag.branch)) begin
                n_slot[j] = r_f1_main;
            end else if (j < int'(r_f1_tag.branch)) begin
                n_slot[j] = r_f1_part[j];
            end else begin
                n_slot[j] = r_f1_part[j-1];
            end
        end
        if (r_f1_tag.degen) begin
            n_slot = '0;
        end else if (n_slot[0][31]) begin
            for (int j = 0; j < 4; j++) begin
                n_slot[j] = (n_slot[j] == Q_MIN) ? Q_MAX : -n_slot[j];
            end
        end
        n_out.quat_w       = n_slot[0];
        n_out.quat_x       = n_slot[1];
        n_out.quat_y       = n_slot[2];
        n_out.quat_z       = n_slot[3];
        n_out.branch_taken = r_f1_tag.branch;
        n_out.degenerate   = r_f1_tag.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f1_valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[tb/rotation_matrix_to_quaternion_core_checker.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core_checker
// Watches both channels, computes the expected quaternion for every accepted
// matrix and compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_checker
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out quat_queue[$];
    int   fail_count = 0;
    int   results_seen = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = quat_queue.size();
    assign o_results_seen = results_seen;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Integer square root of a 128-bit value, one result bit per step.
    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = {root, 2'b01};
            root  = root << 1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    // Quotient of diff * 2^FRAC_BITS by s, magnitude truncated, saturated.
    function automatic logic signed [63:0] div_part(input logic signed [63:0] diff,
                                                    input logic [63:0] s);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] quo;
        neg = diff < 0;
        mag = neg ? 128'(-diff) : 128'(diff);
        quo = (mag << FRAC_BITS) / {64'd0, s};
        if (neg) begin
            if (quo >= 128'd2147483648) return -64'sd2147483648;
            return -$signed(64'(quo));
        end
        if (quo > 128'd2147483647) return 64'sd2147483647;
        return $signed(64'(quo));
    endfunction

    function automatic t_out quat_of(input t_in m);
        logic signed [63:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
        logic signed [63:0] unit, tr, root_arg, mainp;
        logic signed [63:0] q[4];
        logic [63:0]        s;
        t_branch            br;
        t_out               o;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        unit = 64'sd1 <<< FRAC_BITS;
        tr = a00 + a11 + a22;
        for (int k = 0; k < 4; k++) q[k] = 0;
        if (tr > 0) begin
            br = BR_TRACE; root_arg = tr + unit;
        end else if (a00 > a11 && a00 > a22) begin
            br = BR_X; root_arg = unit + a00 - a11 - a22;
        end else if (a11 > a22) begin
            br = BR_Y; root_arg = unit + a11 - a00 - a22;
        end else begin
            br = BR_Z; root_arg = unit + a22 - a00 - a11;
        end
        o.branch_taken = br;
        o.degenerate   = root_arg <= 0;
        if (root_arg > 0) begin
            s = isqrt128(128'(root_arg) << (FRAC_BITS + 2));
            mainp = (s >> 2) > 64'd2147483647 ? 64'sd2147483647 : $signed(s >> 2);
            case (br)
                BR_TRACE: begin
                    q[0] = mainp;
                    q[1] = div_part(a21 - a12, s);
                    q[2] = div_part(a02 - a20, s);
                    q[3] = div_part(a10 - a01, s);
                end
                BR_X: begin
                    q[0] = div_part(a21 - a12, s);
                    q[1] = mainp;
                    q[2] = div_part(a01 + a10, s);
                    q[3] = div_part(a02 + a20, s);
                end
                BR_Y: begin
                    q[0] = div_part(a02 - a20, s);
                    q[1] = div_part(a01 + a10, s);
                    q[2] = mainp;
                    q[3] = div_part(a12 + a21, s);
                end
                default: begin
                    q[0] = div_part(a10 - a01, s);
                    q[1] = div_part(a02 + a20, s);
                    q[2] = div_part(a12 + a21, s);
                    q[3] = mainp;
                end
            endcase
            if (q[0] < 0) begin
                for (int k = 0; k < 4; k++) q[k] = clamp32(-q[k]);
            end
        end
        o.quat_w = q[0][31:0];
        o.quat_x = q[1][31:0];
        o.quat_y = q[2][31:0];
        o.quat_z = q[3][31:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) quat_queue.push_back(quat_of(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (quat_queue.size() == 0) begin
                    report_mismatch("unexpected item", 32'(i_out_data), 0);
                end else begin
                    want = quat_queue.pop_front();
                    if (i_out_data.quat_w !== want.quat_w)
                        report_mismatch("quat_w", i_out_data.quat_w, want.quat_w);
                    if (i_out_data.quat_x !== want.quat_x)
                        report_mismatch("quat_x", i_out_data.quat_x, want.quat_x);
                    if (i_out_data.quat_y !== want.quat_y)
                        report_mismatch("quat_y", i_out_data.quat_y, want.quat_y);
                    if (i_out_data.quat_z !== want.quat_z)
                        report_mismatch("quat_z", i_out_data.quat_z, want.quat_z);
                    if (i_out_data.branch_taken !== want.branch_taken)
                        report_mismatch("branch_taken", 32'(i_out_data.branch_taken),
                                        32'(want.branch_taken));
                    if (i_out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 32'(i_out_data.degenerate),
                                        32'(want.degenerate));
                end
                results_seen++;
            end
        end
    end
endmodule

[tb/rotation_matrix_to_quaternion_core_tb.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core_tb
// Feeds matrices to the quaternion core under several idling patterns and
// lets the checker judge every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 102;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM    = 1600;
    localparam logic signed [31:0] ONE = 32'sh4000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;
    int   fail_count;
    int   pending;
    int   results_seen;

    // Idle and stall chances in percent, changed from phase to phase.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;
    int   items_sent = 0;

    rotation_matrix_to_quaternion_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    rotation_matrix_to_quaternion_core_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The receiver decides its ready fresh on every edge.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The watchdog ends the run when nothing has been accepted for too long.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("rotation_matrix_to_quaternion_core_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one matrix: optional random idle cycles, then valid held until accepted.
    // Valid drops only on idle cycles, so back to back items keep it high.
    task automatic send_matrix(input t_in m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= m;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(5))
            0: return $urandom;
            1: return ONE;
            2: return -ONE;
            3: return $signed(32'($urandom_range(2 * 32'h4000_0000))) - ONE;
            4: return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed(32'($urandom_range(32'h1000))) - 32'sh800;
        endcase
    endfunction

    // Mostly plausible rotations: a signed permutation of the identity with noise,
    // so every branch is reached; the rest are raw random words or rand_elem mixes.
    function automatic t_in rand_matrix();
        logic signed [31:0] e[9];
        int                 perm[3];
        int                 sel;
        t_in                m;
        sel = $urandom_range(9);
        for (int i = 0; i < 9; i++) e[i] = rand_elem();
        if (sel < 6) begin
            perm = '{0, 1, 2};
            if ($urandom_range(1)) begin
                perm = '{0, 2, 1};
            end
            if ($urandom_range(1)) begin
                perm = '{perm[1], perm[0], perm[2]};
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    e[3 * r + c] = $signed(32'($urandom_range(32'h0400_0000)))
                                   - 32'sh0200_0000;
                end
                e[3 * r + perm[r]] = $urandom_range(1) ? ONE - 32'($urandom_range(32'hFFFFF))
                                                       : -ONE + 32'($urandom_range(32'hFFFFF));
            end
        end else if (sel < 8) begin
            for (int i = 0; i < 9; i++) e[i] = $urandom;
        end
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    initial begin
        t_in m;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: identity, its negations per branch, ties, extremes.
        send_matrix({ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE});
        send_matrix({ONE, 32'sd0, 32'sd0, 32'sd0, -ONE, 32'sd0, 32'sd0, 32'sd0, -ONE});
        send_matrix({-ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, -ONE});
        send_matrix({-ONE, 32'sd0, 32'sd0, 32'sd0, -ONE, 32'sd0, 32'sd0, 32'sd0, ONE});
        // Equal diagonal entries, so the later branch must win.
        send_matrix({-ONE, 32'sd5, 32'sd0, 32'sd3, -ONE, 32'sd0, 32'sd0, 32'sd0, -ONE});
        send_matrix({32'sd0, 32'sd7, 32'sd1, 32'sd2, 32'sd0, 32'sd9, 32'sd4, 32'sd8, 32'sd0});
        // Extreme diagonals that still take the trace branch, and a near tie won by y.
        send_matrix({32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sd0,
                     32'sd0, 32'sd0, 32'sh7FFF_FFFF});
        send_matrix({32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0,
                     32'sd0, 32'sd0, 32'sh7FFF_FFFF});
        send_matrix({-ONE, 32'sd0, 32'sd0, 32'sd0, -ONE, 32'sd0, 32'sd0, 32'sd0,
                     -ONE - 32'sd1});
        // Saturating parts and the negated w.
        send_matrix({32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sd1,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0});
        send_matrix({-ONE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -ONE,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, -ONE + 32'sd1});
        send_matrix({ONE, 32'sd0, 32'sd0, 32'sd0, -ONE, 32'sh7FFF_FFFF, 32'sd0,
                     32'sh8000_0000, -ONE});
        send_matrix('1);
        send_matrix('0);
        send_matrix({9{32'sh7FFF_FFFF}});
        send_matrix({9{32'sh8000_0000}});
        send_matrix({9{32'sh5555_5555}});
        send_matrix({9{32'shAAAA_AAAA}});

        // Random phases under the idling patterns.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                m = rand_matrix();
                send_matrix(m);
                // Once per phase the sender holds off until the pipe is empty.
                if (i == N_RANDOM / 10) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        $display("sent %0d matrices over five idling phases, %0d quaternions checked",
                 items_sent, results_seen);
        if (fail_count == 0) begin
            $display("rotation_matrix_to_quaternion_core_tb: PASS");
        end else begin
            $display("rotation_matrix_to_quaternion_core_tb: FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/rmq_pkg.sv
rtl/rotation_matrix_to_quaternion_core.sv
tb/rotation_matrix_to_quaternion_core_checker.sv
tb/rotation_matrix_to_quaternion_core_tb.sv
